/* rtl/assert_macros.svh */
// assertion macros for the chunk allocator
// no dependencies; included by files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* rtl/caa_pkg.sv */
// types, constants and helper functions of the chunk allocator
// no dependencies; used by caa_ctrl and the top level
package caa_pkg;
  localparam int ENTRIES  = 16;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int LEN_W    = IDX_W + 1;
  localparam int AGE_BITS = 32;
  localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};
  localparam logic [15:0] REFS_MAX = 16'hFFFF;

  localparam logic ACT_MAP = 1'b0;
  localparam logic ACT_REL = 1'b1;

  localparam logic [2:0] ST_HIT   = 3'd0;
  localparam logic [2:0] ST_NEW   = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_REL   = 3'd3;
  localparam logic [2:0] ST_WBACK = 3'd4;

  typedef struct packed {
    logic                used;
    logic [31:0]         key;
    logic [31:0]         epoch;
    logic [31:0]         mtime;
    logic                writable;
    logic [31:0]         bytes;
    logic [31:0]         offset;
    logic [31:0]         pages;
    logic [15:0]         refs;
    logic [AGE_BITS-1:0] age;
    logic [IDX_W-1:0]    next;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
  } mem_req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } slot_t;

  function automatic slot_t first_free(input logic [ENTRIES-1:0] chain);
    slot_t r;
    r = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!chain[i]) begin
        r.found = 1'b1;
        r.idx   = IDX_W'(i);
      end
    end
    return r;
  endfunction

  function automatic entry_t make_free(input logic [31:0] off, input logic [31:0] pages,
                                       input logic [AGE_BITS-1:0] age,
                                       input logic [IDX_W-1:0] nxt);
    entry_t e;
    e        = '0;
    e.offset = off;
    e.pages  = pages;
    e.age    = age;
    e.next   = nxt;
    return e;
  endfunction
endpackage

/* rtl/chunk_allocator_with_aging_top.sv */
// chunk allocator with aging reclaim: map and release transactions in, one result each out
// Input channel (in_*): valid/ready. action 0 maps a chunk for a file key, epoch and
// mtime; action 1 releases one reference of table entry in_chunk_index.
// Result channel (out_*): valid/ready, one transaction per input transaction, in order.
// One transaction is worked on at a time; in_ready is high only while the sequencer idles.
// The entry table sits in one ram with registered read data. A map walks the chain in a
// hit scan; on a miss it follows with an aging pass, a merge pass that folds each free entry
// into a free predecessor, and a first-fit scan. A release reads and updates one entry.
// The result is valid when in_ready returns.
// The finished result goes to an output register; the next transaction is accepted while
// it waits, and a stalled receiver holds the block only when a second result is ready.
// Reset (rst_n low, synchronous) empties the table: chain length zero, no slot in use,
// no result pending. No clearing pass is needed.
// Depends on caa_pkg, caa_ram, caa_ctrl and assert_macros.svh.
`include "assert_macros.svh"
module chunk_allocator_with_aging_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [31:0] in_file_key,
  input  logic [31:0] in_epoch,
  input  logic [31:0] in_mtime,
  input  logic [19:0] in_pages_needed,
  input  logic        in_writable,
  input  logic [31:0] in_map_length,
  input  logic [3:0]  in_chunk_index,
  input  logic        in_map_failed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [3:0]  out_chunk_out,
  output logic [31:0] out_page_offset,
  output logic [31:0] out_chunk_pages,
  output logic [31:0] out_key_out,
  output logic [31:0] out_byte_length
);
  caa_pkg::mem_req_t mem_req;
  logic [caa_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;

  caa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_file_key, .in_epoch, .in_mtime,
    .in_pages_needed, .in_writable, .in_map_length, .in_chunk_index, .in_map_failed,
    .out_valid, .out_ready, .out_status, .out_chunk_out, .out_page_offset,
    .out_chunk_pages, .out_key_out, .out_byte_length,
    .mem_req, .mem_wdata, .mem_rdata
  );

  caa_ram #(.DEPTH(caa_pkg::ENTRIES), .WIDTH(caa_pkg::ENTRY_W)) u_ram (
    .clk,
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (mem_rdata),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_wdata)
  );

  `ASSERT_IMPL(a_no_rw_clash, clk, rst_n, mem_req.rd_en && mem_req.wr_en, mem_req.rd_addr != mem_req.wr_addr)
  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
  `ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, out_status <= caa_pkg::ST_WBACK)
endmodule

/* rtl/caa_ram.sv */
// single port pair synchronous ram, registered read data
// generic; no package dependency
module caa_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

/* rtl/caa_ctrl.sv */
// sequencer: hit search, aging, merging, first fit, release, result register
// depends on caa_pkg; drives the entry ram through a mem_req_t
module caa_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_action,
  input  logic [31:0]                  in_file_key,
  input  logic [31:0]                  in_epoch,
  input  logic [31:0]                  in_mtime,
  input  logic [19:0]                  in_pages_needed,
  input  logic                         in_writable,
  input  logic [31:0]                  in_map_length,
  input  logic [3:0]                   in_chunk_index,
  input  logic                         in_map_failed,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_status,
  output logic [3:0]                   out_chunk_out,
  output logic [31:0]                  out_page_offset,
  output logic [31:0]                  out_chunk_pages,
  output logic [31:0]                  out_key_out,
  output logic [31:0]                  out_byte_length,
  output caa_pkg::mem_req_t            mem_req,
  output logic [caa_pkg::ENTRY_W-1:0]  mem_wdata,
  input  logic [caa_pkg::ENTRY_W-1:0]  mem_rdata
);
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_HIT       = 4'd1;
  localparam logic [3:0] S_AGE       = 4'd2;
  localparam logic [3:0] S_MRG_RD    = 4'd3;
  localparam logic [3:0] S_MRG_CUR   = 4'd4;
  localparam logic [3:0] S_MRG_DEC   = 4'd5;
  localparam logic [3:0] S_MRG_V     = 4'd6;
  localparam logic [3:0] S_FIT_START = 4'd7;
  localparam logic [3:0] S_FIT_RD    = 4'd8;
  localparam logic [3:0] S_FIT_EV    = 4'd9;
  localparam logic [3:0] S_CLAIM     = 4'd10;
  localparam logic [3:0] S_CLAIM_WR  = 4'd11;
  localparam logic [3:0] S_REL       = 4'd12;
  localparam logic [3:0] S_EMIT      = 4'd13;

  localparam logic [caa_pkg::LEN_W-1:0] LEN_W1 = caa_pkg::LEN_W'(1);

  logic [3:0] st_r, st_nxt;
  logic [caa_pkg::LEN_W-1:0] len_r, len_nxt, pos_r, pos_nxt;
  logic [caa_pkg::IDX_W-1:0] head_r, head_nxt, s_r, s_nxt, t_r, t_nxt, pick_r, pick_nxt;
  logic [caa_pkg::ENTRIES-1:0] chain_r, chain_nxt;
  caa_pkg::entry_t cur_r, cur_nxt;

  logic [31:0] q_key_r, q_key_nxt, q_epoch_r, q_epoch_nxt, q_mtime_r, q_mtime_nxt;
  logic [31:0] q_bytes_r, q_bytes_nxt, q_need_r, q_need_nxt;
  logic        q_wr_r, q_wr_nxt, q_failed_r, q_failed_nxt;

  logic [2:0]  res_status_r, res_status_nxt;
  logic [3:0]  res_chunk_r, res_chunk_nxt;
  logic [31:0] res_off_r, res_off_nxt, res_pages_r, res_pages_nxt;
  logic [31:0] res_key_r, res_key_nxt, res_bytes_r, res_bytes_nxt;

  logic        ov_r, ov_nxt;
  logic [2:0]  o_status_r, o_status_nxt;
  logic [3:0]  o_chunk_r, o_chunk_nxt;
  logic [31:0] o_off_r, o_off_nxt, o_pages_r, o_pages_nxt;
  logic [31:0] o_key_r, o_key_nxt, o_bytes_r, o_bytes_nxt;

  caa_pkg::entry_t d, w;
  caa_pkg::slot_t  fs;
  logic [caa_pkg::LEN_W-1:0] pos_inc;
  logic [15:0] refs_dec;

  assign d        = caa_pkg::entry_t'(mem_rdata);
  assign fs       = caa_pkg::first_free(chain_r);
  assign pos_inc  = pos_r + LEN_W1;
  assign refs_dec = d.refs - 16'd1;
  assign mem_wdata = w;

  assign in_ready        = (st_r == S_IDLE);
  assign out_valid       = ov_r;
  assign out_status      = o_status_r;
  assign out_chunk_out   = o_chunk_r;
  assign out_page_offset = o_off_r;
  assign out_chunk_pages = o_pages_r;
  assign out_key_out     = o_key_r;
  assign out_byte_length = o_bytes_r;

  always_comb begin
    st_nxt = st_r; len_nxt = len_r; pos_nxt = pos_r; head_nxt = head_r;
    s_nxt = s_r; t_nxt = t_r; pick_nxt = pick_r; chain_nxt = chain_r; cur_nxt = cur_r;
    q_key_nxt = q_key_r; q_epoch_nxt = q_epoch_r; q_mtime_nxt = q_mtime_r;
    q_bytes_nxt = q_bytes_r; q_need_nxt = q_need_r; q_wr_nxt = q_wr_r;
    q_failed_nxt = q_failed_r;
    res_status_nxt = res_status_r; res_chunk_nxt = res_chunk_r; res_off_nxt = res_off_r;
    res_pages_nxt = res_pages_r; res_key_nxt = res_key_r; res_bytes_nxt = res_bytes_r;
    ov_nxt = ov_r & ~out_ready;
    o_status_nxt = o_status_r; o_chunk_nxt = o_chunk_r; o_off_nxt = o_off_r;
    o_pages_nxt = o_pages_r; o_key_nxt = o_key_r; o_bytes_nxt = o_bytes_r;
    mem_req = '0;
    w = cur_r;

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          q_key_nxt = in_file_key; q_epoch_nxt = in_epoch; q_mtime_nxt = in_mtime;
          q_bytes_nxt = in_map_length; q_need_nxt = {12'd0, in_pages_needed};
          q_wr_nxt = in_writable; q_failed_nxt = in_map_failed;
          pos_nxt = '0;
          if (in_action == caa_pkg::ACT_REL) begin
            s_nxt = in_chunk_index[caa_pkg::IDX_W-1:0];
            mem_req.rd_en = 1'b1; mem_req.rd_addr = in_chunk_index[caa_pkg::IDX_W-1:0];
            st_nxt = S_REL;
          end else if (len_r == '0) begin
            st_nxt = S_FIT_START;
          end else begin
            s_nxt = head_r;
            mem_req.rd_en = 1'b1; mem_req.rd_addr = head_r;
            st_nxt = S_HIT;
          end
        end
      end
      S_HIT: begin
        if (d.used && d.epoch == q_epoch_r && d.mtime == q_mtime_r &&
            q_need_r <= d.pages && d.key == q_key_r) begin
          w = d;
          w.age = d.age | caa_pkg::AGE_TOP;
          if (d.refs != caa_pkg::REFS_MAX) w.refs = d.refs + 16'd1;
          mem_req.wr_en = 1'b1; mem_req.wr_addr = s_r;
          res_status_nxt = caa_pkg::ST_HIT; res_chunk_nxt = 4'(s_r);
          res_off_nxt = d.offset; res_pages_nxt = d.pages;
          res_key_nxt = d.key; res_bytes_nxt = d.bytes;
          st_nxt = S_EMIT;
        end else if (pos_inc < len_r) begin
          s_nxt = d.next; pos_nxt = pos_inc;
          mem_req.rd_en = 1'b1; mem_req.rd_addr = d.next;
        end else begin
          s_nxt = head_r; pos_nxt = '0;
          mem_req.rd_en = 1'b1; mem_req.rd_addr = head_r;
          st_nxt = S_AGE;
        end
      end
      S_AGE: begin
        w = d;
        if (d.used && d.refs == '0 && d.age == '0) begin
          w.used = 1'b0; w.epoch = '0;
        end else begin
          w.age = d.age >> 1;
        end
        mem_req.wr_en = 1'b1; mem_req.wr_addr = s_r;
        if (pos_inc < len_r) begin
          s_nxt = d.next; pos_nxt = pos_inc;
          mem_req.rd_en = 1'b1; mem_req.rd_addr = d.next;
        end else begin
          s_nxt = head_r; pos_nxt = '0;
          st_nxt = S_MRG_RD;
        end
      end
      S_MRG_RD: begin
        mem_req.rd_en = 1'b1; mem_req.rd_addr = s_r;
        st_nxt = S_MRG_CUR;
      end
      S_MRG_CUR: begin
        cur_nxt = d;
        st_nxt = S_MRG_DEC;
      end
      S_MRG_DEC: begin
        if (!cur_r.used && pos_inc < len_r) begin
          t_nxt = cur_r.next;
          mem_req.rd_en = 1'b1; mem_req.rd_addr = cur_r.next;
          st_nxt = S_MRG_V;
        end else if (pos_inc < len_r) begin
          s_nxt = cur_r.next; pos_nxt = pos_inc;
          mem_req.rd_en = 1'b1; mem_req.rd_addr = cur_r.next;
          st_nxt = S_MRG_CUR;
        end else begin
          st_nxt = S_FIT_START;
        end
      end
      S_MRG_V: begin
        if (!d.used) begin
          w = cur_r;
          w.pages = cur_r.pages + d.pages;
          w.next = d.next;
          cur_nxt = w;
          mem_req.wr_en = 1'b1; mem_req.wr_addr = s_r;
          chain_nxt[t_r] = 1'b0;
          len_nxt = len_r - LEN_W1;
        end else begin
          s_nxt = t_r; pos_nxt = pos_inc; cur_nxt = d;
        end
        st_nxt = S_MRG_DEC;
      end
      S_FIT_START: begin
        pos_nxt = '0;
        if (len_r == '0) begin
          if (!fs.found) begin
            res_status_nxt = caa_pkg::ST_FULL; res_chunk_nxt = '0; res_off_nxt = '0;
            res_pages_nxt = '0; res_key_nxt = '0; res_bytes_nxt = '0;
            st_nxt = S_EMIT;
          end else begin
            w = caa_pkg::make_free('0, q_need_r, '0, '0);
            mem_req.wr_en = 1'b1; mem_req.wr_addr = fs.idx;
            chain_nxt[fs.idx] = 1'b1;
            head_nxt = fs.idx; s_nxt = fs.idx; len_nxt = LEN_W1;
            st_nxt = S_FIT_RD;
          end
        end else begin
          s_nxt = head_r;
          st_nxt = S_FIT_RD;
        end
      end
      S_FIT_RD: begin
        mem_req.rd_en = 1'b1; mem_req.rd_addr = s_r;
        st_nxt = S_FIT_EV;
      end
      S_FIT_EV: begin
        if (!d.used && d.pages >= q_need_r) begin
          pick_nxt = s_r; cur_nxt = d;
          st_nxt = S_CLAIM;
        end else if (pos_inc == len_r) begin
          if (!d.used) begin
            cur_nxt = d; cur_nxt.pages = q_need_r; pick_nxt = s_r;
            st_nxt = S_CLAIM;
          end else if (!fs.found) begin
            res_status_nxt = caa_pkg::ST_FULL; res_chunk_nxt = '0; res_off_nxt = '0;
            res_pages_nxt = '0; res_key_nxt = '0; res_bytes_nxt = '0;
            st_nxt = S_EMIT;
          end else begin
            w = d; w.next = fs.idx;
            mem_req.wr_en = 1'b1; mem_req.wr_addr = s_r;
            chain_nxt[fs.idx] = 1'b1;
            len_nxt = len_r + LEN_W1;
            cur_nxt = caa_pkg::make_free(d.offset + d.pages, q_need_r, '0, '0);
            pick_nxt = fs.idx;
            st_nxt = S_CLAIM;
          end
        end else begin
          s_nxt = d.next; pos_nxt = pos_inc;
          mem_req.rd_en = 1'b1; mem_req.rd_addr = d.next;
        end
      end
      S_CLAIM: begin
        if (cur_r.pages > q_need_r) begin
          if (!fs.found) begin
            res_status_nxt = caa_pkg::ST_FULL; res_chunk_nxt = '0; res_off_nxt = '0;
            res_pages_nxt = '0; res_key_nxt = '0; res_bytes_nxt = '0;
            st_nxt = S_EMIT;
          end else begin
            w = caa_pkg::make_free(cur_r.offset + q_need_r, cur_r.pages - q_need_r,
                                   caa_pkg::AGE_TOP, cur_r.next);
            mem_req.wr_en = 1'b1; mem_req.wr_addr = fs.idx;
            chain_nxt[fs.idx] = 1'b1;
            len_nxt = len_r + LEN_W1;
            cur_nxt.next = fs.idx; cur_nxt.pages = q_need_r;
            st_nxt = S_CLAIM_WR;
          end
        end else begin
          st_nxt = S_CLAIM_WR;
        end
      end
      S_CLAIM_WR: begin
        w = cur_r;
        w.used = 1'b1; w.key = q_key_r; w.epoch = q_epoch_r; w.mtime = q_mtime_r;
        w.writable = q_wr_r; w.bytes = q_bytes_r; w.refs = 16'd1; w.age = '0;
        mem_req.wr_en = 1'b1; mem_req.wr_addr = pick_r;
        res_status_nxt = caa_pkg::ST_NEW; res_chunk_nxt = 4'(pick_r);
        res_off_nxt = cur_r.offset; res_pages_nxt = cur_r.pages;
        res_key_nxt = q_key_r; res_bytes_nxt = q_bytes_r;
        st_nxt = S_EMIT;
      end
      S_REL: begin
        res_chunk_nxt = 4'(s_r);
        res_status_nxt = caa_pkg::ST_REL;
        if (!chain_r[s_r] || !d.used) begin
          res_off_nxt = '0; res_pages_nxt = '0; res_key_nxt = '0; res_bytes_nxt = '0;
        end else begin
          res_off_nxt = d.offset; res_pages_nxt = d.pages;
          res_key_nxt = d.key; res_bytes_nxt = d.bytes;
          if (d.refs != '0) begin
            w = d; w.refs = refs_dec;
            mem_req.wr_en = 1'b1; mem_req.wr_addr = s_r;
            if (!q_failed_r && refs_dec == '0 && d.writable) begin
              res_status_nxt = caa_pkg::ST_WBACK;
            end
          end
        end
        st_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          o_status_nxt = res_status_r; o_chunk_nxt = res_chunk_r; o_off_nxt = res_off_r;
          o_pages_nxt = res_pages_r; o_key_nxt = res_key_r; o_bytes_nxt = res_bytes_r;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; len_r <= '0; head_r <= '0; chain_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; len_r <= len_nxt; head_r <= head_nxt; chain_r <= chain_nxt;
      ov_r <= ov_nxt;
    end
    pos_r <= pos_nxt; s_r <= s_nxt; t_r <= t_nxt; pick_r <= pick_nxt; cur_r <= cur_nxt;
    q_key_r <= q_key_nxt; q_epoch_r <= q_epoch_nxt; q_mtime_r <= q_mtime_nxt;
    q_bytes_r <= q_bytes_nxt; q_need_r <= q_need_nxt; q_wr_r <= q_wr_nxt;
    q_failed_r <= q_failed_nxt;
    res_status_r <= res_status_nxt; res_chunk_r <= res_chunk_nxt; res_off_r <= res_off_nxt;
    res_pages_r <= res_pages_nxt; res_key_r <= res_key_nxt; res_bytes_r <= res_bytes_nxt;
    o_status_r <= o_status_nxt; o_chunk_r <= o_chunk_nxt; o_off_r <= o_off_nxt;
    o_pages_r <= o_pages_nxt; o_key_r <= o_key_nxt; o_bytes_r <= o_bytes_nxt;
  end
endmodule
